// ===== rtl/core/fel_pkg.sv =====
package fel_pkg;

   localparam int DELAY_W = 14;
   localparam int GAIN_W  = 16;
   localparam int CSR_W   = 16;
   localparam int INDEX_W = 2;

   typedef enum logic [INDEX_W-1:0] {
      CSR_ECHO_DELAY      = 2'd0,
      CSR_ECHO_DECAY      = 2'd1,
      CSR_SMOOTHING_ALPHA = 2'd2
   } csr_index_type;

   // commands from controller to datapath
   typedef struct packed {
      logic capture;    // latch the dry beat
      logic rd_prev;    // address the previous output instead of the echo tap
      logic mul_echo;   // decay * echo tap
      logic mix;        // add echo, latch previous output
      logic mul_lp;     // alpha * (x - prev)
      logic add_lp;     // x = prev + rounded product
      logic commit;     // saturate, write history, load output register
   } fel_cmd_type;

   typedef struct packed {
      logic lp_en;
      logic out_free;
   } fel_status_type;

endpackage

// ===== rtl/core/fel_ram.sv =====
module fel_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 16384
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/fel_ctrl.sv =====
module fel_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  fel_pkg::fel_status_type status,
   output fel_pkg::fel_cmd_type    cmd
);
   import fel_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ECHO,
      S_MIX,
      S_LP1_MUL,
      S_LP1_ADD,
      S_LP2_MUL,
      S_LP2_ADD,
      S_OUT
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_ECHO;
            end
         end
         S_ECHO: begin
            cmd.rd_prev  = 1'b1;
            cmd.mul_echo = 1'b1;
            state_in     = S_MIX;
         end
         S_MIX: begin
            cmd.mix  = 1'b1;
            state_in = status.lp_en ? S_LP1_MUL : S_OUT;
         end
         S_LP1_MUL: begin
            cmd.mul_lp = 1'b1;
            state_in   = S_LP1_ADD;
         end
         S_LP1_ADD: begin
            cmd.add_lp = 1'b1;
            state_in   = S_LP2_MUL;
         end
         S_LP2_MUL: begin
            cmd.mul_lp = 1'b1;
            state_in   = S_LP2_ADD;
         end
         S_LP2_ADD: begin
            cmd.add_lp = 1'b1;
            state_in   = S_OUT;
         end
         S_OUT: begin
            // hold until the output register can take the beat
            if (status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/core/fel_dp.sv =====
module fel_dp #(
   parameter int HISTORY_DEPTH = 16384,
   parameter int SAMPLE_WIDTH  = 24
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write,
   input  logic [fel_pkg::INDEX_W-1:0]    csr_index,
   input  logic [fel_pkg::CSR_W-1:0]      csr_wdata,
   input  logic signed [SAMPLE_WIDTH-1:0] req_dry_sample,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_wet_sample,
   input  fel_pkg::fel_cmd_type           cmd,
   output fel_pkg::fel_status_type        status
);
   import fel_pkg::*;

   localparam int AW = $clog2(HISTORY_DEPTH);
   localparam int FW = $clog2(HISTORY_DEPTH + 1);
   localparam int CW = ((AW > DELAY_W) ? AW : DELAY_W) + 1;
   localparam int GW = (FW > DELAY_W) ? FW : DELAY_W;
   localparam int XW = SAMPLE_WIDTH + 2;
   localparam int PW = XW + GAIN_W + 1;
   localparam int Q15_FRAC = 15;
   localparam logic [GAIN_W-1:0]     Q15_ONE    = GAIN_W'(32768);
   localparam logic signed [PW-1:0]  ROUND_HALF = PW'(16384);
   localparam logic [AW-1:0]         LAST_ADDR  = AW'(HISTORY_DEPTH - 1);
   localparam logic [FW-1:0]         FULL_COUNT = FW'(HISTORY_DEPTH);

   logic [DELAY_W-1:0] delay_ff;
   logic [GAIN_W-1:0]  decay_ff;
   logic [GAIN_W-1:0]  alpha_ff;
   logic [AW-1:0]      wp_ff, wp_in;
   logic [FW-1:0]      fill_ff, fill_in;
   logic signed [XW-1:0] x_ff, x_in;
   logic signed [XW-1:0] prev_ff, prev_in;
   logic signed [PW-1:0] prod_ff, prod_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_WIDTH-1:0] rsp_sample_ff, rsp_sample_in;

   logic [GAIN_W-1:0]    decay_clamp, alpha_clamp;
   logic signed [GAIN_W:0] mul_a;
   logic signed [XW-1:0] mul_b;
   logic signed [PW-1:0] prod_rnd;
   logic signed [XW-1:0] rnd;
   logic signed [XW-1:0] hist_x;
   logic [CW-1:0]        tap_diff, tap_wrap;
   logic [AW-1:0]        echo_addr, prev_addr, rd_addr;
   logic [SAMPLE_WIDTH-1:0] rd_data;
   logic                 echo_en;
   logic                 no_ovf;
   logic signed [SAMPLE_WIDTH-1:0] sat;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff <= '0;
         decay_ff <= '0;
         alpha_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_ECHO_DELAY:      delay_ff <= csr_wdata[DELAY_W-1:0];
            CSR_ECHO_DECAY:      decay_ff <= csr_wdata[GAIN_W-1:0];
            CSR_SMOOTHING_ALPHA: alpha_ff <= csr_wdata[GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   assign decay_clamp = (decay_ff > Q15_ONE) ? Q15_ONE : decay_ff;
   assign alpha_clamp = (alpha_ff > Q15_ONE) ? Q15_ONE : alpha_ff;

   assign echo_en = (delay_ff != '0) && (GW'(fill_ff) >= GW'(delay_ff));
   assign status.lp_en    = (fill_ff > FW'(1));
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   // history addressing, wraps modulo the depth
   assign tap_diff  = {{(CW-AW){1'b0}}, wp_ff} - {{(CW-DELAY_W){1'b0}}, delay_ff};
   assign tap_wrap  = tap_diff[CW-1] ? (tap_diff + CW'(HISTORY_DEPTH)) : tap_diff;
   assign echo_addr = tap_wrap[AW-1:0];
   assign prev_addr = (wp_ff == '0) ? LAST_ADDR : (wp_ff - AW'(1));
   assign rd_addr   = cmd.rd_prev ? prev_addr : echo_addr;

   fel_ram #(
      .WIDTH (SAMPLE_WIDTH),
      .DEPTH (HISTORY_DEPTH)
   ) u_hist (
      .clock   (clock),
      .wr_en   (cmd.commit),
      .wr_addr (wp_ff),
      .wr_data (sat),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign hist_x = XW'($signed(rd_data));

   // one shared multiplier
   assign mul_a   = cmd.mul_echo ? $signed({1'b0, decay_clamp}) : $signed({1'b0, alpha_clamp});
   assign mul_b   = cmd.mul_echo ? hist_x : (x_ff - prev_ff);
   assign prod_in = PW'(mul_a * mul_b);

   // round half up to Q3.23
   assign prod_rnd = (prod_ff + ROUND_HALF) >>> Q15_FRAC;
   assign rnd      = prod_rnd[XW-1:0];

   always_comb begin
      x_in    = x_ff;
      prev_in = prev_ff;
      if (cmd.capture) begin
         x_in = XW'(req_dry_sample);
      end else if (cmd.mix) begin
         prev_in = hist_x;
         if (echo_en) begin
            x_in = x_ff + rnd;
         end
      end else if (cmd.add_lp) begin
         x_in = prev_ff + rnd;
      end
   end

   assign no_ovf = (&x_ff[XW-1:SAMPLE_WIDTH-1]) | ~(|x_ff[XW-1:SAMPLE_WIDTH-1]);
   assign sat    = no_ovf ? x_ff[SAMPLE_WIDTH-1:0]
                          : {x_ff[XW-1], {(SAMPLE_WIDTH-1){~x_ff[XW-1]}}};

   assign wp_in   = (wp_ff == LAST_ADDR) ? '0 : (wp_ff + AW'(1));
   assign fill_in = (fill_ff == FULL_COUNT) ? fill_ff : (fill_ff + FW'(1));

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_sample_in = rsp_sample_ff;
      if (cmd.commit) begin
         rsp_valid_in  = 1'b1;
         rsp_sample_in = sat;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff        <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.commit) begin
            wp_ff   <= wp_in;
            fill_ff <= fill_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff          <= x_in;
      prev_ff       <= prev_in;
      rsp_sample_ff <= rsp_sample_in;
      if (cmd.mul_echo || cmd.mul_lp) begin
         prod_ff <= prod_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_wet_sample = rsp_sample_ff;

endmodule

// ===== rtl/core/feedback_echo_lowpass_chain.sv =====
// Feedback echo followed by two one-pole low-pass passes, one sample per beat.
// Input channel req_valid/req_ready carries a signed dry sample; result channel
// rsp_valid/rsp_ready returns exactly one wet sample per accepted beat.
// csr_write/csr_index/csr_wdata set echo delay (0), echo decay (1) and the
// smoothing alpha (2); write them only while the block is idle.
// Steps after accept: ECHO, MIX and OUT while the history holds at most one
// sample, and ECHO, MIX, LP1_MUL, LP1_ADD, LP2_MUL, LP2_ADD, OUT afterwards;
// one item is in flight at a time, so a new beat is taken only after the last
// commits. The steps follow from the single history RAM read port (echo tap,
// then previous output) and one multiplier for echo and both low-pass passes.
// The finished sample sits in an output register, so the next beat is accepted
// while it waits; if the receiver stalls, the following sample holds in its
// final step until the output register frees.
// Reset clears configuration, write pointer and fill count; the history RAM is
// not cleared, entries are used only after they have been written.
module feedback_echo_lowpass_chain #(
   parameter int HISTORY_DEPTH = 16384,
   parameter int SAMPLE_WIDTH  = 24
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write,
   input  logic [fel_pkg::INDEX_W-1:0]    csr_index,
   input  logic [fel_pkg::CSR_W-1:0]      csr_wdata,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic signed [SAMPLE_WIDTH-1:0] req_dry_sample,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_wet_sample
);
   import fel_pkg::*;

   fel_cmd_type    cmd;
   fel_status_type status;

   fel_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   fel_dp #(
      .HISTORY_DEPTH (HISTORY_DEPTH),
      .SAMPLE_WIDTH  (SAMPLE_WIDTH)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_dry_sample (req_dry_sample),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_wet_sample (rsp_wet_sample),
      .cmd            (cmd),
      .status         (status)
   );

endmodule
